// ===== hw/rtl/segc_pkg.sv =====
// Shared types and fixed widths for the segment/circle obstacle checker.
// No dependencies; imported by the controller, the datapath and the top level.
package segc_pkg;

    localparam int COORD_W = 16;  // Q8.8 coordinate and radius width
    localparam int CFG_W   = 5;   // obstacle_count register width
    localparam int SLOT_W  = 4;   // slot field width

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic query_start;  // latch segment end points, clear hit flag
        logic load_wr;      // write the obstacle table
        logic issue;        // read one table entry into the pipeline
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic busy;         // entries still in flight
        logic hit_any;      // some entry so far was hit
    } sts_t;

endpackage

// ===== hw/rtl/segment_circle_obstacle_check_core.sv =====
// Segment versus circle-table obstacle checker, top level.
// Query: from acceptance the controller walks the entries in use at one entry per cycle into
// the 7-stage hit pipeline, then a drain check and a finish state give the result.
// The input reopens as the result appears; a query whose result finds the output register
// full holds until it frees.
// Reset (rst_n low, asynchronous): count register 0, no result pending; table undefined.
module segment_circle_obstacle_check_core #(
    parameter int MAX_OBSTACLES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [segc_pkg::SLOT_W-1:0]         slot,
    input  logic signed [segc_pkg::COORD_W-1:0] centre_x,
    input  logic signed [segc_pkg::COORD_W-1:0] centre_y,
    input  logic [segc_pkg::COORD_W-1:0]        radius,
    input  logic signed [segc_pkg::COORD_W-1:0] start_x,
    input  logic signed [segc_pkg::COORD_W-1:0] start_y,
    input  logic signed [segc_pkg::COORD_W-1:0] end_x,
    input  logic signed [segc_pkg::COORD_W-1:0] end_y,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                path_free,
    // configuration channel: obstacle_count
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [segc_pkg::CFG_W-1:0]          cfg_data
);
    import segc_pkg::*;

    // table address width; one bit minimum for a single-entry table
    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

    cmd_t          cmd;
    sts_t          sts;
    logic [AW-1:0] rd_addr;

    // Controller: accept transactions, walk the entries in use, hold the result
    // in the output register until the consumer takes it.
    segc_ctrl #(
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .AW            (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .path_free (path_free),
        .cmd       (cmd),
        .sts       (sts),
        .rd_addr   (rd_addr)
    );

    // Datapath: obstacle memory and the exact integer hit test; ORs the hit of
    // every entry of the query into one flag.
    segc_datapath #(
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .AW            (AW)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .rd_addr  (rd_addr),
        .slot     (slot),
        .centre_x (centre_x),
        .centre_y (centre_y),
        .radius   (radius),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y)
    );

endmodule

// ===== hw/rtl/segc_ctrl.sv =====
// Controller for the obstacle checker: handshakes, count register, entry walk.
// Depends on segc_pkg; drives the datapath through cmd_t, reads sts_t.
module segc_ctrl #(
    parameter int MAX_OBSTACLES = 16,
    parameter int AW = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [segc_pkg::CFG_W-1:0]   cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         path_free,
    output segc_pkg::cmd_t               cmd,
    input  segc_pkg::sts_t               sts,
    output logic [AW-1:0]                rd_addr
);
    import segc_pkg::*;

    localparam int CW = $clog2(MAX_OBSTACLES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ISSUE  = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] count_reg, count_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             path_free_reg, path_free_next;
    logic             accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign path_free = path_free_reg;
    assign accept    = in_valid && in_ready;
    assign rd_addr   = idx_reg[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        path_free_next  = path_free_reg;
        cmd.query_start = accept && (req_type == REQ_QUERY);
        cmd.load_wr     = accept && (req_type == REQ_LOAD);
        cmd.issue       = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.query_start)
                begin
                    // clamp the count to the table depth
                    if (32'(count_reg) > MAX_OBSTACLES)
                    begin
                        n_next = CW'(MAX_OBSTACLES);
                    end
                    else
                    begin
                        n_next = CW'(count_reg);
                    end
                    idx_next   = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (idx_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold the verdict until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    path_free_next = !sts.hit_any;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        path_free_reg <= path_free_next;
    end

endmodule

// ===== hw/rtl/segc_datapath.sv =====
// Datapath for the obstacle checker: obstacle memory and the per-entry
// hit pipeline (exact quadratic test, no square root). Depends on segc_pkg.
module segc_datapath #(
    parameter int MAX_OBSTACLES = 16,
    parameter int AW = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  segc_pkg::cmd_t                      cmd,
    output segc_pkg::sts_t                      sts,
    input  logic [AW-1:0]                       rd_addr,
    input  logic [segc_pkg::SLOT_W-1:0]         slot,
    input  logic signed [segc_pkg::COORD_W-1:0] centre_x,
    input  logic signed [segc_pkg::COORD_W-1:0] centre_y,
    input  logic [segc_pkg::COORD_W-1:0]        radius,
    input  logic signed [segc_pkg::COORD_W-1:0] start_x,
    input  logic signed [segc_pkg::COORD_W-1:0] start_y,
    input  logic signed [segc_pkg::COORD_W-1:0] end_x,
    input  logic signed [segc_pkg::COORD_W-1:0] end_y
);
    import segc_pkg::*;

    localparam int D_W   = COORD_W + 1;    // differences
    localparam int P_W   = 2 * D_W;        // signed products of differences
    localparam int S_W   = P_W + 1;        // h and c
    localparam int M_W   = 2 * D_W;        // magnitudes of h, a, c (split in halves)
    localparam int HALF  = D_W;
    localparam int PP_W  = 2 * HALF;       // partial products
    localparam int Q_W   = 2 * M_W;        // h^2 and a*c
    localparam int T_W   = S_W + 3;        // root-side sums
    localparam int ENT_W = 3 * COORD_W;

    typedef struct packed {
        logic a_zero;
        logic c_neg;
        logic c_pos;
        logic near_ok;
        logic far_ok;
    } flags_t;

    // Obstacle memory
    logic [ENT_W-1:0] mem [MAX_OBSTACLES];
    logic [ENT_W-1:0] ent_reg;
    logic             wr_ok;

    assign wr_ok = cmd.load_wr && (32'(slot) < MAX_OBSTACLES);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[AW'(slot)] <= {centre_x, centre_y, radius};
        end
        if (cmd.issue)
        begin
            ent_reg <= mem[rd_addr];
        end
    end

    // Per-query values
    logic signed [COORD_W-1:0] sx_reg, sy_reg;
    logic signed [D_W-1:0]     dx_reg, dy_reg;
    logic signed [P_W-1:0]     dxx_reg, dyy_reg;
    logic [M_W-1:0]            a_reg;

    // Pipeline
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [D_W-1:0]     fx_reg, fy_reg;
    logic [COORD_W-1:0]        r2_reg;
    logic signed [P_W-1:0]     pdx_reg, pdy_reg, pfx_reg, pfy_reg;
    logic [2*COORD_W-1:0]      prr_reg;
    logic signed [S_W-1:0]     h_reg, c_reg;
    logic [M_W-1:0]            habs_reg, cpos_reg, a5_reg;
    flags_t                    f5_reg, f6_reg, f7_reg;
    logic [PP_W-1:0]           ph_hh_reg, ph_hl_reg, ph_ll_reg;
    logic [PP_W-1:0]           pac_hh_reg, pac_hl_reg, pac_lh_reg, pac_ll_reg;
    logic [Q_W-1:0]            h2_reg, ac_reg;
    logic                      hit_reg, hit_next;

    logic signed [S_W-1:0]     h_next, c_next;
    logic signed [T_W-1:0]     h_t, a_t, c_t, sum_near, sum_far;
    flags_t                    f5_next;
    logic                      hit7;

    always_comb
    begin
        h_next = S_W'(pdx_reg) + S_W'(pdy_reg);
        c_next = S_W'(pfx_reg) + S_W'(pfy_reg) - $signed({3'b000, prr_reg});

        h_t      = T_W'(h_reg);
        c_t      = T_W'(c_reg);
        a_t      = $signed(T_W'(a_reg));
        sum_near = h_t + a_t;
        sum_far  = a_t + (h_t <<< 1) + c_t;

        f5_next.a_zero  = (a_reg == '0);
        f5_next.c_neg   = c_reg[S_W-1];
        f5_next.c_pos   = !c_reg[S_W-1] && (c_reg != '0);
        f5_next.near_ok = h_reg[S_W-1] || c_reg[S_W-1];
        f5_next.far_ok  = (sum_near > 0) || sum_far[T_W-1];

        // discriminant check only matters when c is positive
        if (f7_reg.a_zero)
        begin
            hit7 = f7_reg.c_neg;
        end
        else
        begin
            hit7 = (!f7_reg.c_pos || (h2_reg >= ac_reg)) && f7_reg.near_ok && f7_reg.far_ok;
        end

        if (cmd.query_start)
        begin
            hit_next = 1'b0;
        end
        else
        begin
            hit_next = hit_reg || (v7_reg && hit7);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= cmd.issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            sx_reg <= start_x;
            sy_reg <= start_y;
            dx_reg <= D_W'(end_x) - D_W'(start_x);
            dy_reg <= D_W'(end_y) - D_W'(start_y);
        end
        // a settles through dxx/dyy and a_reg after the query starts, before any entry needs it
        dxx_reg <= dx_reg * dx_reg;
        dyy_reg <= dy_reg * dy_reg;
        a_reg   <= M_W'(dxx_reg + dyy_reg);

        // stage 2: offsets from the centre
        fx_reg <= D_W'(sx_reg) - D_W'($signed(ent_reg[ENT_W-1 -: COORD_W]));
        fy_reg <= D_W'(sy_reg) - D_W'($signed(ent_reg[2*COORD_W-1 -: COORD_W]));
        r2_reg <= ent_reg[COORD_W-1:0];

        // stage 3: products
        pdx_reg <= dx_reg * fx_reg;
        pdy_reg <= dy_reg * fy_reg;
        pfx_reg <= fx_reg * fx_reg;
        pfy_reg <= fy_reg * fy_reg;
        prr_reg <= r2_reg * r2_reg;

        // stage 4: h and c
        h_reg <= h_next;
        c_reg <= c_next;

        // stage 5: magnitudes and root-side flags
        habs_reg <= h_reg[S_W-1] ? M_W'(-h_reg) : M_W'(h_reg);
        cpos_reg <= c_reg[S_W-1] ? '0 : M_W'(c_reg);
        a5_reg   <= a_reg;
        f5_reg   <= f5_next;

        // stage 6: partial products of h^2 and a*c
        ph_hh_reg  <= habs_reg[M_W-1:HALF] * habs_reg[M_W-1:HALF];
        ph_hl_reg  <= habs_reg[M_W-1:HALF] * habs_reg[HALF-1:0];
        ph_ll_reg  <= habs_reg[HALF-1:0] * habs_reg[HALF-1:0];
        pac_hh_reg <= a5_reg[M_W-1:HALF] * cpos_reg[M_W-1:HALF];
        pac_hl_reg <= a5_reg[M_W-1:HALF] * cpos_reg[HALF-1:0];
        pac_lh_reg <= a5_reg[HALF-1:0] * cpos_reg[M_W-1:HALF];
        pac_ll_reg <= a5_reg[HALF-1:0] * cpos_reg[HALF-1:0];
        f6_reg     <= f5_reg;

        // stage 7: assemble the wide products
        h2_reg <= (Q_W'(ph_hh_reg) << (2 * HALF)) + (Q_W'(ph_hl_reg) << (HALF + 1))
                  + Q_W'(ph_ll_reg);
        ac_reg <= (Q_W'(pac_hh_reg) << (2 * HALF))
                  + ((Q_W'(pac_hl_reg) + Q_W'(pac_lh_reg)) << HALF)
                  + Q_W'(pac_ll_reg);
        f7_reg <= f6_reg;
    end

    assign sts.busy    = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg || v6_reg || v7_reg;
    assign sts.hit_any = hit_reg;

endmodule

// ===== bench/tb_segment_circle_obstacle_check_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for segment_circle_obstacle_check_core: a directed table, then random phases.
// Depends on segc_pkg and the core RTL; path_free is predicted by an exact integer segment test.

module tb_segment_circle_obstacle_check_core;
    import segc_pkg::*;

    localparam int NUM_SLOTS      = 16;
    localparam int RANDOM_ITEMS   = 1530;
    // A query walks at most NUM_SLOTS entries plus the hit pipeline; hold this long
    // after the last result before touching obstacle_count, and at the very end.
    localparam int SETTLE_CYCLES  = 40;
    // Longest correct quiet stretch is the settle pause or one query plus a full
    // receiver stall; this is many times that.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic        [COORD_W-1:0] r;
    } obstacle_t;

    typedef struct packed {
        logic                      op;
        logic [SLOT_W-1:0]         slot;
        obstacle_t                 obs;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } request_t;

    typedef enum logic {ROW_CONFIG, ROW_REQUEST} row_kind_t;
    // How a directed query is judged: by the predictor, or by a value typed in the table
    typedef enum logic [1:0] {CHECK_MODEL, EXPECT_FREE, EXPECT_BLOCKED} verdict_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CFG_W-1:0] count;
        request_t         req;
        verdict_t         verdict;
    } stim_row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic                      req_type  = REQ_LOAD;
    logic [SLOT_W-1:0]         slot      = '0;
    logic signed [COORD_W-1:0] centre_x  = '0;
    logic signed [COORD_W-1:0] centre_y  = '0;
    logic [COORD_W-1:0]        radius    = '0;
    logic signed [COORD_W-1:0] start_x   = '0;
    logic signed [COORD_W-1:0] start_y   = '0;
    logic signed [COORD_W-1:0] end_x     = '0;
    logic signed [COORD_W-1:0] end_y     = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      path_free;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_W-1:0]          cfg_data  = '0;

    // Shadow copy of the block: obstacle table, count register, results owed
    obstacle_t        shadow_obstacles [NUM_SLOTS];
    logic [CFG_W-1:0] shadow_count = '0;
    bit               expected_path_free_q [$];

    int          mismatches      = 0;
    int unsigned loads_sent      = 0;
    int unsigned queries_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned count_writes    = 0;
    int          burst_left      = 0;
    int          ready_run       = 0;
    int          stall_run       = 0;
    bit          steady_stretch  = 1'b0;  // both sides run without idling

    segment_circle_obstacle_check_core #(
        .MAX_OBSTACLES(NUM_SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .slot     (slot),
        .centre_x (centre_x),
        .centre_y (centre_y),
        .radius   (radius),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .path_free(path_free),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Exact hit test with no square root. With d = E - S and f = S - C:
    // a = |d|^2, h = d.f, c = |f|^2 - r^2. A hit needs a real root (h^2 >= a*c,
    // only in question when S is outside), the far root past t = 0 and the near
    // root before t = 1. A point segment hits only when strictly inside.
    function automatic bit segment_hits_circle(request_t q, obstacle_t o);
        longint             dx;
        longint             dy;
        longint             fx;
        longint             fy;
        longint             rad;
        longint             a;
        longint             h;
        longint             c;
        longint             h_mag;
        logic signed [127:0] h_sq;
        logic signed [127:0] ac;
        dx  = longint'($signed(q.ex)) - longint'($signed(q.sx));
        dy  = longint'($signed(q.ey)) - longint'($signed(q.sy));
        fx  = longint'($signed(q.sx)) - longint'($signed(o.cx));
        fy  = longint'($signed(q.sy)) - longint'($signed(o.cy));
        rad = o.r;
        a   = dx * dx + dy * dy;
        h   = dx * fx + dy * fy;
        c   = fx * fx + fy * fy - rad * rad;
        if (a == 0)
            return c < 0;
        if (c > 0)
        begin
            h_mag = (h < 0) ? -h : h;
            h_sq  = 128'(h_mag) * 128'(h_mag);
            ac    = 128'(a) * 128'(c);
            if (h_sq < ac)
                return 1'b0;
        end
        return (h < 0 || c < 0) && (h + a > 0 || a + 2 * h + c < 0);
    endfunction

    // Walk the entries in use; a count past the table covers the whole table
    function automatic bit predict_path_free(request_t q);
        int in_use;
        in_use = (shadow_count > NUM_SLOTS) ? NUM_SLOTS : int'(shadow_count);
        for (int i = 0; i < in_use; i++)
        begin
            if (segment_hits_circle(q, shadow_obstacles[i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic stim_row_t config_row(logic [CFG_W-1:0] n);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_CONFIG;
        row.count   = n;
        row.verdict = CHECK_MODEL;
        return row;
    endfunction

    // Query fields of a load sit at their extremes; the block must ignore them
    function automatic stim_row_t load_row(logic [SLOT_W-1:0] s, logic signed [COORD_W-1:0] cx,
                                           logic signed [COORD_W-1:0] cy, logic [COORD_W-1:0] r);
        stim_row_t row;
        row          = '0;
        row.kind     = ROW_REQUEST;
        row.verdict  = CHECK_MODEL;
        row.req.op   = REQ_LOAD;
        row.req.slot = s;
        row.req.obs  = '{cx, cy, r};
        row.req.sx   = 16'sh8000;
        row.req.sy   = 16'sh8000;
        row.req.ex   = 16'sh7FFF;
        row.req.ey   = 16'sh7FFF;
        return row;
    endfunction

    function automatic stim_row_t query_row(logic signed [COORD_W-1:0] sx,
                                            logic signed [COORD_W-1:0] sy,
                                            logic signed [COORD_W-1:0] ex,
                                            logic signed [COORD_W-1:0] ey, verdict_t verdict);
        stim_row_t row;
        row          = '0;
        row.kind     = ROW_REQUEST;
        row.verdict  = verdict;
        row.req.op   = REQ_QUERY;
        row.req.slot = '1;
        row.req.obs  = '{16'sh7FFF, 16'sh8000, 16'hFFFF};
        row.req.sx   = sx;
        row.req.sy   = sy;
        row.req.ex   = ex;
        row.req.ey   = ey;
        return row;
    endfunction

    // Move a coordinate by up to +/- 2^bits LSBs, clamped to the Q8.8 range
    function automatic logic signed [COORD_W-1:0] jitter(logic signed [COORD_W-1:0] base,
                                                         int unsigned bits);
        int offset;
        int moved;
        offset = $signed($urandom) >>> (31 - bits);
        moved  = int'(base) + offset;
        if (moved > 32767)
            moved = 32767;
        if (moved < -32768)
            moved = -32768;
        return moved[COORD_W-1:0];
    endfunction

    // Random obstacle: centres either anywhere or clustered near the origin,
    // radii spread over scales from 10 bits to the full 16 bits
    function automatic request_t random_load();
        request_t rq;
        rq.op     = REQ_LOAD;
        rq.slot   = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        rq.obs.cx = ($urandom_range(0, 1) == 0) ? COORD_W'($urandom)
                                                : jitter('0, $urandom_range(6, 15));
        rq.obs.cy = ($urandom_range(0, 1) == 0) ? COORD_W'($urandom)
                                                : jitter('0, $urandom_range(6, 15));
        rq.obs.r  = COORD_W'($urandom >> $urandom_range(0, 22));
        rq.sx     = COORD_W'($urandom);
        rq.sy     = COORD_W'($urandom);
        rq.ex     = COORD_W'($urandom);
        rq.ey     = COORD_W'($urandom);
        return rq;
    endfunction

    // Random segment: mostly aimed around a loaded obstacle at a random scale so
    // that near misses and grazes come up; some point segments, some anywhere
    function automatic request_t random_query();
        request_t    rq;
        obstacle_t   target;
        int unsigned spread;
        int unsigned shape;
        target    = shadow_obstacles[$urandom_range(0, NUM_SLOTS - 1)];
        spread    = $urandom_range(3, 16);
        shape     = $urandom_range(0, 7);
        rq.op     = REQ_QUERY;
        rq.slot   = SLOT_W'($urandom);
        rq.obs.cx = COORD_W'($urandom);
        rq.obs.cy = COORD_W'($urandom);
        rq.obs.r  = COORD_W'($urandom);
        if (shape == 0)
        begin
            rq.sx = COORD_W'($urandom);
            rq.sy = COORD_W'($urandom);
            rq.ex = COORD_W'($urandom);
            rq.ey = COORD_W'($urandom);
        end
        else
        begin
            rq.sx = jitter(target.cx, spread);
            rq.sy = jitter(target.cy, spread);
            rq.ex = (shape == 1) ? rq.sx : jitter(target.cx, spread);
            rq.ey = (shape == 1) ? rq.sy : jitter(target.cy, spread);
        end
        return rq;
    endfunction

    // Append one owed path_free at the tail of the queue
    task automatic owe_path_free(bit value);
        expected_path_free_q = {expected_path_free_q, value};
    endtask

    // Insert a random gap between bursts; valid drops only when a gap follows
    task automatic sender_pause();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap        = steady_stretch ? 0 : $urandom_range(1, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drive one request transaction and hold it until accepted; on acceptance
    // advance the shadow table or queue the path_free owed for a query
    task automatic send_request(request_t rq, verdict_t verdict);
        bit predicted;
        in_valid <= 1'b1;
        req_type <= rq.op;
        slot     <= rq.slot;
        centre_x <= rq.obs.cx;
        centre_y <= rq.obs.cy;
        radius   <= rq.obs.r;
        start_x  <= rq.sx;
        start_y  <= rq.sy;
        end_x    <= rq.ex;
        end_y    <= rq.ey;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (rq.op == REQ_LOAD)
        begin
            shadow_obstacles[rq.slot] = rq.obs;
            loads_sent++;
        end
        else
        begin
            predicted = predict_path_free(rq);
            case (verdict)
                EXPECT_FREE:    owe_path_free(1'b1);
                EXPECT_BLOCKED: owe_path_free(1'b0);
                default:        owe_path_free(predicted);
            endcase
            queries_sent++;
        end
    endtask

    // Change obstacle_count only with the block idle: drain every owed result,
    // then hold off long enough for a trailing load or walk to settle
    task automatic write_obstacle_count(logic [CFG_W-1:0] n);
        in_valid <= 1'b0;
        while (expected_path_free_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        shadow_count = n;
        count_writes++;
    endtask

    // Result side: compare each accepted path_free with the oldest owed value,
    // and alternate ready runs with stalls unless in a steady stretch
    always @(posedge clk)
    begin : result_check
        bit expected_free;
        if (out_valid === 1'b1 && out_ready)
        begin
            if (expected_path_free_q.size() == 0)
            begin
                $display("%0t: path_free expected none, got %0b", $time, path_free);
                mismatches++;
            end
            else
            begin
                expected_free = expected_path_free_q.pop_front();
                results_checked++;
                if (path_free !== expected_free)
                begin
                    $display("%0t: path_free expected %0b, got %0b",
                             $time, expected_free, path_free);
                    mismatches++;
                end
            end
        end
        if (steady_stretch || ready_run > 0)
        begin
            out_ready <= 1'b1;
            if (ready_run > 0)
                ready_run--;
        end
        else if (stall_run > 0)
        begin
            out_ready <= 1'b0;
            stall_run--;
        end
        else
        begin
            ready_run = $urandom_range(1, 12);
            stall_run = $urandom_range(1, 20);
            out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if no channel moves a transaction for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_segment_circle_obstacle_check_core NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t        directed_rows [$];
        int unsigned      random_sent;
        int unsigned      phase;
        int unsigned      phase_len;
        logic [CFG_W-1:0] next_count;

        // Slot 0: circle of radius 1.0 at the origin; slots 1 and 2 sit at the
        // corners with the largest and a zero radius.
        directed_rows = '{
            // nothing in use right after reset: any segment is free
            query_row(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, EXPECT_FREE),
            load_row(4'd0, 16'sd0, 16'sd0, 16'd256),
            load_row(4'd1, 16'sh7FFF, 16'sh7FFF, 16'hFFFF),
            load_row(4'd2, 16'sh8000, 16'sh8000, 16'd0),
            config_row(5'd1),
            // point segments: inside, exactly on the rim, outside
            query_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, EXPECT_BLOCKED),
            query_row(16'sd256, 16'sd0, 16'sd256, 16'sd0, EXPECT_FREE),
            query_row(16'sd512, 16'sd0, 16'sd512, 16'sd0, EXPECT_FREE),
            // straight through the middle
            query_row(-16'sd512, 16'sd0, 16'sd512, 16'sd0, EXPECT_BLOCKED),
            // grazing the top of the circle counts as a hit
            query_row(-16'sd512, 16'sd256, 16'sd512, 16'sd256, EXPECT_BLOCKED),
            // aimed at the circle but stopping short: a ray would hit, the segment not
            query_row(-16'sd1024, 16'sd0, -16'sd512, 16'sd0, EXPECT_FREE),
            // pointing away from it
            query_row(16'sd512, 16'sd0, 16'sd1024, 16'sd0, EXPECT_FREE),
            // starting inside, leaving the circle
            query_row(16'sd0, 16'sd0, 16'sd1024, 16'sd0, EXPECT_BLOCKED),
            // wholly inside
            query_row(-16'sd64, 16'sd0, 16'sd64, 16'sd0, CHECK_MODEL),
            config_row(5'd3),
            // corner to corner across the whole range
            query_row(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, CHECK_MODEL),
            query_row(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, CHECK_MODEL),
            // point on a zero-radius circle is not inside it
            query_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, CHECK_MODEL),
            // point at the centre of the largest circle
            query_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, EXPECT_BLOCKED),
            config_row(5'd0),
            query_row(-16'sd64, 16'sd0, 16'sd64, 16'sd0, EXPECT_FREE)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                write_obstacle_count(directed_rows[i].count);
            else
            begin
                sender_pause();
                send_request(directed_rows[i].req, directed_rows[i].verdict);
            end
        end

        // Fill the whole table so that any count may be used from here on
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            request_t fill;
            fill      = random_load();
            fill.slot = SLOT_W'(s);
            sender_pause();
            send_request(fill, CHECK_MODEL);
        end
        random_sent = NUM_SLOTS;

        // Random phases: each picks an obstacle_count, extremes included, then
        // sends mostly queries with loads mixed in to keep the table moving
        for (phase = 0; random_sent < RANDOM_ITEMS; phase++)
        begin
            case (phase % 6)
                0:       next_count = CFG_W'(NUM_SLOTS);
                1:       next_count = '1;
                2:       next_count = CFG_W'(1);
                3:       next_count = '0;
                4:       next_count = CFG_W'($urandom_range(2, NUM_SLOTS - 1));
                default: next_count = CFG_W'($urandom_range(NUM_SLOTS + 1, 30));
            endcase
            write_obstacle_count(next_count);
            steady_stretch = (phase % 4 == 3);
            phase_len      = (next_count == 0) ? 30 : $urandom_range(80, 160);
            repeat (phase_len)
            begin
                sender_pause();
                if ($urandom_range(0, 4) == 0)
                    send_request(random_load(), CHECK_MODEL);
                else
                    send_request(random_query(), CHECK_MODEL);
                random_sent++;
            end
        end

        in_valid <= 1'b0;
        while (expected_path_free_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d obstacle loads and %0d segment queries over %0d count settings",
                 loads_sent, queries_sent, count_writes);
        $display("Compared %0d path_free results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("tb_segment_circle_obstacle_check_core OK");
        else
            $display("tb_segment_circle_obstacle_check_core NOT OK");
        $finish;
    end

endmodule
